[sv/twlru_pkg.sv]
`timescale 1ns / 1ps

package twlru_pkg;

    // Cache geometry.
    localparam int BLOCK_BYTES = 32;
    localparam int SET_COUNT   = 16;
    localparam int MEM_BYTES   = 4096;
    localparam int WAY_COUNT   = 2;

    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int OFS_W       = $clog2(BLOCK_BYTES);
    localparam int SET_W       = $clog2(SET_COUNT);
    localparam int WAY_W       = $clog2(WAY_COUNT);
    localparam int TAG_W       = ADDR_W - OFS_W - SET_W;
    localparam int BLK_W       = ADDR_W - OFS_W;
    localparam int LINE_COUNT  = SET_COUNT * WAY_COUNT;
    localparam int LINE_IDX_W  = SET_W + WAY_W;
    localparam int LINE_BYTES  = LINE_COUNT * BLOCK_BYTES;
    localparam int FILL_W      = OFS_W + 1;

    // Data and statistics widths.
    localparam int DATA_W      = 8;
    localparam int CNT_W       = 32;
    localparam int RATE_W      = 7;
    localparam int QUO_W       = RATE_W + 1;
    localparam int NUM_W       = CNT_W + RATE_W;
    localparam int DSH_W       = CNT_W + QUO_W;
    localparam int DIV_STEPS   = QUO_W + 1;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [RATE_W-1:0] PCT      = RATE_W'(100);
    localparam logic [DATA_W-1:0] MEM_INIT = '1;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Stream word widths.
    localparam int IN_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + RATE_W + 7) / 8) * 8;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic lookup;
        logic rd_hit;
        logic fill_step;
        logic div_start;
        logic resp_load;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_write;
        logic found;
        logic fill_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[sv/twlru_ram.sv]
`timescale 1ns / 1ps

module twlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/twlru_div.sv]
`timescale 1ns / 1ps

// Computes min(100, floor(100 * miss / acc)), or 0 when acc is zero.
// The multiply is registered on start, then a restoring divider takes one quotient bit a cycle.
module twlru_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [twlru_pkg::CNT_W-1:0]      i_miss,
    input  logic [twlru_pkg::CNT_W-1:0]      i_acc,
    output logic                             o_done,
    output logic [twlru_pkg::RATE_W-1:0]     o_rate
);

    logic                             r_busy;
    logic                             r_done;
    logic [twlru_pkg::STEP_W-1:0]     r_cnt;
    logic [twlru_pkg::NUM_W-1:0]      r_rem;
    logic [twlru_pkg::DSH_W-1:0]      r_dsh;
    logic [twlru_pkg::QUO_W-1:0]      r_quo;
    logic                             r_sat;
    logic                             r_zero;
    logic                             w_ge;

    assign w_ge = twlru_pkg::DSH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == twlru_pkg::STEP_W'(twlru_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= twlru_pkg::NUM_W'(i_miss) * twlru_pkg::NUM_W'(twlru_pkg::PCT);
            r_dsh  <= {i_acc, twlru_pkg::QUO_W'(0)};
            r_zero <= (i_acc == '0);
            r_quo  <= '0;
            r_sat  <= 1'b0;
        end else if (r_busy) begin
            // The first step only checks whether the quotient fits in QUO_W bits.
            if (r_cnt == '0) begin
                r_sat <= w_ge;
            end else begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[twlru_pkg::NUM_W-1:0];
                end
                r_quo <= {r_quo[twlru_pkg::QUO_W-2:0], w_ge};
            end
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;

    always_comb begin
        if (r_zero) begin
            o_rate = '0;
        end else if (r_sat || (r_quo > twlru_pkg::QUO_W'(twlru_pkg::PCT))) begin
            o_rate = twlru_pkg::PCT;
        end else begin
            o_rate = r_quo[twlru_pkg::RATE_W-1:0];
        end
    end

endmodule

[sv/twlru_dp.sv]
`timescale 1ns / 1ps

module twlru_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  twlru_pkg::t_cmd                     i_cmd,
    output twlru_pkg::t_status                  o_status,
    input  logic [twlru_pkg::IN_TDATA_W-1:0]    i_in_tdata,
    input  logic                                i_in_tuser,
    output logic                                o_out_tvalid,
    output logic [twlru_pkg::OUT_TDATA_W-1:0]   o_out_tdata,
    output logic                                o_out_tuser,
    input  logic                                i_out_tready
);

    localparam int TROW_W = twlru_pkg::WAY_COUNT * twlru_pkg::TAG_W;
    localparam int LADDR_W = $clog2(twlru_pkg::LINE_BYTES);

    // Latched access.
    logic                              r_kind;
    logic [twlru_pkg::ADDR_W-1:0]      r_addr;
    logic [twlru_pkg::DATA_W-1:0]      r_wdata;

    // Lookup results.
    logic [TROW_W-1:0]                 r_tags;
    logic                              r_hit;
    logic [twlru_pkg::WAY_W-1:0]       r_way;
    logic [twlru_pkg::DATA_W-1:0]      r_rdata;

    // Control state.
    logic [twlru_pkg::ADDR_W-1:0]      r_clr;
    logic [twlru_pkg::FILL_W-1:0]      r_fill;
    logic [twlru_pkg::LINE_COUNT-1:0]  r_valid;
    logic [twlru_pkg::SET_COUNT-1:0]   r_victim;
    logic [twlru_pkg::CNT_W-1:0]       r_acc;
    logic [twlru_pkg::CNT_W-1:0]       r_miss;

    // Output register.
    logic                              r_out_valid;
    logic                              r_out_hit;
    logic [twlru_pkg::DATA_W-1:0]      r_out_rdata;
    logic [twlru_pkg::RATE_W-1:0]      r_out_rate;

    logic [twlru_pkg::SET_W-1:0]       w_in_set;
    logic [twlru_pkg::SET_W-1:0]       w_set;
    logic [twlru_pkg::OFS_W-1:0]       w_off;
    logic [twlru_pkg::TAG_W-1:0]       w_tag;
    logic [twlru_pkg::BLK_W-1:0]       w_blk;
    logic [twlru_pkg::WAY_COUNT-1:0]   w_way_hit;
    logic                              w_found;
    logic [twlru_pkg::WAY_W-1:0]       w_hit_way;
    logic [twlru_pkg::OFS_W-1:0]       w_fill_prev;
    logic                              w_fill_done;
    logic                              w_is_write;
    logic [TROW_W-1:0]                 w_tag_row;
    logic [TROW_W-1:0]                 w_tag_new;

    logic                              w_mem_we;
    logic [twlru_pkg::ADDR_W-1:0]      w_mem_waddr;
    logic [twlru_pkg::DATA_W-1:0]      w_mem_wdata;
    logic [twlru_pkg::ADDR_W-1:0]      w_mem_raddr;
    logic [twlru_pkg::DATA_W-1:0]      w_mem_rdata;

    logic                              w_line_we;
    logic [LADDR_W-1:0]                w_line_waddr;
    logic [twlru_pkg::DATA_W-1:0]      w_line_wdata;
    logic [LADDR_W-1:0]                w_line_raddr;
    logic [twlru_pkg::DATA_W-1:0]      w_line_rdata;

    logic [twlru_pkg::SET_W-1:0]       w_tag_raddr;
    logic                              w_div_done;
    logic [twlru_pkg::RATE_W-1:0]      w_rate;

    function automatic logic [twlru_pkg::OFS_W-1:0] w_fill_minus_one(
        input logic [twlru_pkg::FILL_W-1:0] cnt
    );
        logic [twlru_pkg::FILL_W-1:0] dec;
        dec = cnt - twlru_pkg::FILL_W'(1);
        return dec[twlru_pkg::OFS_W-1:0];
    endfunction

    assign w_in_set = i_in_tdata[twlru_pkg::OFS_W +: twlru_pkg::SET_W];
    assign w_set    = r_addr[twlru_pkg::OFS_W +: twlru_pkg::SET_W];
    assign w_off    = r_addr[twlru_pkg::OFS_W-1:0];
    assign w_tag    = r_addr[twlru_pkg::ADDR_W-1 -: twlru_pkg::TAG_W];
    assign w_blk    = r_addr[twlru_pkg::ADDR_W-1:twlru_pkg::OFS_W];
    assign w_is_write = (r_kind == twlru_pkg::KIND_WRITE);

    // Tag compare over both ways of the set; the lower way wins a double match.
    always_comb begin
        for (int w = 0; w < twlru_pkg::WAY_COUNT; w++) begin
            w_way_hit[w] = r_valid[{w_set, twlru_pkg::WAY_W'(w)}] &&
                           (w_tag_row[w*twlru_pkg::TAG_W +: twlru_pkg::TAG_W] == w_tag);
        end
    end

    assign w_found     = |w_way_hit;
    assign w_hit_way   = twlru_pkg::WAY_W'(!w_way_hit[0]);
    assign w_fill_prev = w_fill_minus_one(r_fill);
    assign w_fill_done = (r_fill == twlru_pkg::FILL_W'(twlru_pkg::BLOCK_BYTES));

    always_comb begin
        w_tag_new = r_tags;
        w_tag_new[r_way*twlru_pkg::TAG_W +: twlru_pkg::TAG_W] = w_tag;
    end

    // Backing memory: cleared to all ones after reset, written through on every write.
    assign w_mem_we    = i_cmd.clear_step || (i_cmd.lookup && w_is_write);
    assign w_mem_waddr = i_cmd.clear_step ? r_clr : r_addr;
    assign w_mem_wdata = i_cmd.clear_step ? twlru_pkg::MEM_INIT : r_wdata;
    assign w_mem_raddr = {w_blk, r_fill[twlru_pkg::OFS_W-1:0]};

    twlru_ram #(
        .WIDTH (twlru_pkg::DATA_W),
        .DEPTH (twlru_pkg::MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // Line data: written on a write hit, or one byte a cycle during a fill.
    assign w_line_we    = (i_cmd.lookup && w_is_write && w_found) ||
                          (i_cmd.fill_step && (r_fill != '0));
    assign w_line_waddr = i_cmd.lookup ? {w_set, w_hit_way, w_off}
                                       : {w_set, r_way, w_fill_prev};
    assign w_line_wdata = i_cmd.lookup ? r_wdata : w_mem_rdata;
    assign w_line_raddr = {w_set, w_hit_way, w_off};

    twlru_ram #(
        .WIDTH (twlru_pkg::DATA_W),
        .DEPTH (twlru_pkg::LINE_BYTES)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (w_line_waddr),
        .i_wdata (w_line_wdata),
        .i_raddr (w_line_raddr),
        .o_rdata (w_line_rdata)
    );

    // Tags of both ways share one row per set.
    assign w_tag_raddr = i_cmd.accept ? w_in_set : w_set;

    twlru_ram #(
        .WIDTH (TROW_W),
        .DEPTH (twlru_pkg::SET_COUNT)
    ) u_tag (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_step && w_fill_done),
        .i_waddr (w_set),
        .i_wdata (w_tag_new),
        .i_raddr (w_tag_raddr),
        .o_rdata (w_tag_row)
    );

    twlru_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_miss  (r_miss),
        .i_acc   (r_acc),
        .o_done  (w_div_done),
        .o_rate  (w_rate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_fill      <= '0;
            r_valid     <= '0;
            r_victim    <= '1;
            r_acc       <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.lookup) begin
                r_fill <= '0;
                r_acc  <= r_acc + 1'b1;
                if (!w_found) begin
                    r_miss <= r_miss + 1'b1;
                end
                if (w_is_write && w_found) begin
                    r_victim[w_set] <= ~w_hit_way;
                end
            end
            if (i_cmd.rd_hit) begin
                r_victim[w_set] <= ~r_way;
            end
            if (i_cmd.fill_step) begin
                r_fill <= r_fill + 1'b1;
                if (w_fill_done) begin
                    r_valid[{w_set, r_way}] <= 1'b1;
                    r_victim[w_set]         <= ~r_way;
                end
            end
            if (i_cmd.resp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_in_tuser;
            r_addr  <= i_in_tdata[twlru_pkg::ADDR_W-1:0];
            r_wdata <= i_in_tdata[twlru_pkg::ADDR_W +: twlru_pkg::DATA_W];
        end
        if (i_cmd.lookup) begin
            r_tags  <= w_tag_row;
            r_hit   <= w_found;
            r_way   <= w_found ? w_hit_way : r_victim[w_set];
            r_rdata <= '0;
        end
        if (i_cmd.rd_hit) begin
            r_rdata <= w_line_rdata;
        end
        if (i_cmd.resp_load) begin
            r_out_hit   <= r_hit;
            r_out_rdata <= r_rdata;
            r_out_rate  <= w_rate;
        end
    end

    assign o_status.clear_done = (r_clr == '1);
    assign o_status.is_write   = w_is_write;
    assign o_status.found      = w_found;
    assign o_status.fill_done  = w_fill_done;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = !r_out_valid || i_out_tready;

    assign o_out_tvalid = r_out_valid;
    assign o_out_tuser  = r_out_hit;
    assign o_out_tdata  = twlru_pkg::OUT_TDATA_W'({r_out_rate, r_out_rdata});

endmodule

[sv/twlru_ctrl.sv]
`timescale 1ns / 1ps

module twlru_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  twlru_pkg::t_status    i_status,
    output twlru_pkg::t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_LOOKUP  = 8'b0000_0100,
        S_RDHIT   = 8'b0000_1000,
        S_FILL    = 8'b0001_0000,
        S_DIVGO   = 8'b0010_0000,
        S_DIVWAIT = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (i_status.is_write) begin
                    n_state = S_DIVGO;
                end else if (i_status.found) begin
                    n_state = S_RDHIT;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_RDHIT: begin
                o_cmd.rd_hit = 1'b1;
                n_state      = S_DIVGO;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_done) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (i_status.div_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.resp_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/two_way_lru_cache_model.sv]
`timescale 1ns / 1ps

// Two-way set-associative byte cache in front of a 4096-byte memory, with
// 32-byte blocks, 16 sets, LRU replacement and write-through without
// write-allocate. Each access word enters on the s_axis channel and produces
// exactly one result word on the m_axis channel: the hit flag, the byte read
// on a read hit (zero otherwise), and the running miss rate in percent.
// After reset the block sweeps the backing memory, writing all ones into one
// byte per cycle, and holds s_axis_tready low until the sweep is done. Valid
// bits, LRU bits and the access and miss counters are cleared at once.
// One access is in flight at a time. A write goes from the lookup straight to
// the miss-rate update, a read hit first reads the line, and a read miss first
// copies the block byte by byte through the single memory read port; the miss
// rate comes from a multiply followed by a bit-serial divider. A result word
// sits in an output register, so a new access is accepted while it waits; if
// m_axis_tready stays low, the next access stops just before its own result
// and waits for the register to drain.
module two_way_lru_cache_model (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] address, [19:12] write_data, [23:20] zero
    input  logic [twlru_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] kind (0 read, 1 write)
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] read_data, [14:8] miss rate in percent, [15] zero
    output logic [twlru_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] hit
    output logic                               m_axis_tuser
);

    twlru_pkg::t_cmd    w_cmd;
    twlru_pkg::t_status w_status;

    twlru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    twlru_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tuser   (s_axis_tuser),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser),
        .i_out_tready (m_axis_tready)
    );

    // A miss never returns data.
    a_miss_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[twlru_pkg::DATA_W-1:0] == '0))
        else $error("result without hit carries nonzero read data");

    // The reported rate never exceeds one hundred percent.
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[twlru_pkg::DATA_W +: twlru_pkg::RATE_W] <= twlru_pkg::PCT))
        else $error("miss rate above one hundred percent");

    // Once a word is taken the block works on it alone.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // A result is loaded only when the output register is free to take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !w_cmd.resp_load)
        else $error("result loaded over a word still waiting");

endmodule
